// ===== hdl/kmp_pkg.sv =====
// kmp_pkg: shared types and constants for the k-transaction max-profit core.
// Used by kmp_cell and k_transaction_max_profit_core. No dependencies.

package kmp_pkg;

    localparam int HOLD_W  = 34;   // signed best-holding value
    localparam int SOLD_W  = 32;   // unsigned best-sold value, saturating
    localparam int PRICE_W = 32;   // widest price the chain carries
    localparam int CFG_W   = 7;    // transactions register

    // Transaction payload moving one cell per cycle down the chain while it advances.
    typedef struct packed {
        logic               first;
        logic               last;
        logic [PRICE_W-1:0] price;
        logic [SOLD_W-1:0]  sold;    // new sold value of the previous level
        logic [SOLD_W-1:0]  result;  // sold value captured at level k
    } token_t;

endpackage

// ===== hdl/kmp_cell.sv =====
// kmp_cell: one transaction level of the max-profit chain.
// Holds hold/sold for its level; depends on kmp_pkg.

module kmp_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  kmp_pkg::token_t tok_in,
    input  logic            capture,
    output logic            out_valid,
    output kmp_pkg::token_t tok_out
);
    import kmp_pkg::*;

    logic signed [HOLD_W-1:0] hold_reg, hold_next;
    logic        [SOLD_W-1:0] sold_reg, sold_next;
    logic                     valid_reg;
    token_t                   tok_reg, tok_next;

    logic signed [HOLD_W:0]   sum_w, sold_w, cand_w;
    logic signed [HOLD_W-1:0] buy_w, price_s;
    logic        [SOLD_W-1:0] sell_val;

    always_comb
    begin
        price_s = $signed(HOLD_W'(tok_in.price));
        sum_w   = (HOLD_W+1)'(hold_reg) + $signed((HOLD_W+1)'(tok_in.price));
        sold_w  = $signed((HOLD_W+1)'(sold_reg));
        cand_w  = (sum_w > sold_w) ? sum_w : sold_w;
        // cand_w never negative; anything past 32 bits saturates
        if (cand_w[HOLD_W:SOLD_W] != '0)
            sell_val = '1;
        else
            sell_val = cand_w[SOLD_W-1:0];
        buy_w = $signed(HOLD_W'(tok_in.sold)) - price_s;

        tok_next = tok_in;
        if (tok_in.first)
        begin
            hold_next     = -price_s;
            sold_next     = '0;
        end
        else
        begin
            hold_next     = (buy_w > hold_reg) ? buy_w : hold_reg;
            sold_next     = sell_val;
        end
        tok_next.sold = sold_next;
        if (capture)
            tok_next.result = sold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            sold_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                hold_reg <= hold_next;
                sold_reg <= sold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign tok_out   = tok_reg;

endmodule

// ===== hdl/k_transaction_max_profit_core.sv =====
// k_transaction_max_profit_core: top level of the k-transaction max-profit block.
// Depends on kmp_pkg and kmp_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one price per transaction,
//   with first (restart the sequence) and last (report the answer) marks.
//   Output channel (out_valid / out_stall) carries profit, the best total
//   over at most k buy-sell pairs, saturating at 2^32-1. Only transactions
//   marked last produce an output; others produce nothing.
//   k is the transactions register, written through cfg_wr_en/cfg_wr_data
//   while the block is idle. k = 0 reports 0; k above MAX_LEVELS acts as
//   MAX_LEVELS.
// Structure:
//   A skewed chain of MAX_LEVELS cells, one per transaction level. A price
//   enters cell 0 and walks one cell per cycle unless stalled, each cell
//   updating its own hold/sold pair and passing its new sold value to the
//   next level. The level-k cell copies its sold value to the token's result.
// Timing:
//   A price passes the MAX_LEVELS cell registers, then the output register,
//   before out_valid; one price is accepted every cycle while in_stall is low.
// Reset: all levels hold 0, chain empty, k = 1.
// Stall: the chain freezes only when a result at the chain tail meets a
//   full, stalled output register; in_stall then rises until it drains.

module k_transaction_max_profit_core #(
    parameter int MAX_LEVELS = 64,
    parameter int PRICE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kmp_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PRICE_BITS-1:0]     price,
    input  logic                      first,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [kmp_pkg::SOLD_W-1:0] profit
);
    import kmp_pkg::*;

    // wide enough for both the register and MAX_LEVELS
    localparam int LVL_CW = ($clog2(MAX_LEVELS + 1) > CFG_W) ?
                            $clog2(MAX_LEVELS + 1) : CFG_W;

    logic [CFG_W-1:0]  trans_reg;
    logic [LVL_CW-1:0] k_ext;
    logic              adv;

    logic              out_valid_reg;
    logic [SOLD_W-1:0] profit_reg;

    logic   [MAX_LEVELS:0] v_chain;
    token_t                t_chain [MAX_LEVELS+1];
    logic [MAX_LEVELS-1:0] capture;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trans_reg <= CFG_W'(1);
        else if (cfg_wr_en)
            trans_reg <= cfg_wr_data;
    end

    assign k_ext = LVL_CW'(trans_reg);

    // chain head: previous-level sold is 0 for level 1
    assign v_chain[0]        = in_valid;
    assign t_chain[0].first  = first;
    assign t_chain[0].last   = last;
    assign t_chain[0].price  = PRICE_W'(price);
    assign t_chain[0].sold   = '0;
    assign t_chain[0].result = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEVELS; gi++)
        begin : g_lvl
            if (gi == MAX_LEVELS - 1)
            begin : g_top
                assign capture[gi] = (k_ext >= LVL_CW'(gi + 1));
            end
            else
            begin : g_mid
                assign capture[gi] = (k_ext == LVL_CW'(gi + 1));
            end

            kmp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (v_chain[gi]),
                .tok_in    (t_chain[gi]),
                .capture   (capture[gi]),
                .out_valid (v_chain[gi+1]),
                .tok_out   (t_chain[gi+1])
            );
        end
    endgenerate

    // freeze only when a result at the tail cannot move on
    assign adv = !(v_chain[MAX_LEVELS] && t_chain[MAX_LEVELS].last &&
                   out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && v_chain[MAX_LEVELS] && t_chain[MAX_LEVELS].last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_chain[MAX_LEVELS] && t_chain[MAX_LEVELS].last)
            profit_reg <= t_chain[MAX_LEVELS].result;
    end

    assign out_valid = out_valid_reg;
    assign profit    = profit_reg;

endmodule

// ===== hdl/kmp_checker.sv =====
// kmp_checker: port-level checks for k_transaction_max_profit_core.
// Bound to the top level below; depends on kmp_pkg for widths.

module kmp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [kmp_pkg::SOLD_W-1:0] profit
);
    import kmp_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(profit))
        else $error("profit changed while stalled");

    // input backpressure only comes from a stuck result
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

endmodule

bind k_transaction_max_profit_core kmp_checker u_kmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .profit    (profit)
);

// ===== dv/kmp_profit_checker.sv =====
`timescale 1ns / 100ps
// kmp_profit_checker: watches the price and profit channels of the max-profit core,
// predicts each profit from its own copy of the level state, and counts mismatches.
// Depends on kmp_pkg for widths.

module kmp_profit_checker #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [kmp_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [PRICE_BITS-1:0]      price,
    input  logic                       first,
    input  logic                       last,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [kmp_pkg::SOLD_W-1:0] profit,
    output int                         fail_count,
    output int                         open_results
);

    localparam longint SOLD_CAP = 64'd4294967295;

    logic signed [kmp_pkg::HOLD_W-1:0] hold_best [LEVELS];
    logic [kmp_pkg::SOLD_W-1:0]        sold_best [LEVELS];
    logic [kmp_pkg::CFG_W-1:0]         k_limit;
    logic [kmp_pkg::SOLD_W-1:0]        profit_expected [$];

    // One day of the level recurrence; queues a profit when the day closes a sequence.
    function automatic void apply_price(input logic [PRICE_BITS-1:0] p_in,
                                        input logic restart, input logic report);
        longint p;
        longint s;
        longint h;
        longint carry;
        int     k;
        p = longint'(p_in);
        if (restart)
        begin
            h = -p;
            for (int i = 0; i < LEVELS; i++)
            begin
                hold_best[i] = h[kmp_pkg::HOLD_W-1:0];
                sold_best[i] = '0;
            end
        end
        else
        begin
            carry = 0;
            for (int i = 0; i < LEVELS; i++)
            begin
                s = longint'(sold_best[i]);
                h = longint'(hold_best[i]);
                if (h + p > s)
                    s = h + p;
                if (s > SOLD_CAP)
                    s = SOLD_CAP;
                sold_best[i] = s[kmp_pkg::SOLD_W-1:0];
                // buy against the sold value this level below just reached
                if (carry - p > h)
                    h = carry - p;
                hold_best[i] = h[kmp_pkg::HOLD_W-1:0];
                carry = s;
            end
        end
        if (report)
        begin
            k = int'(k_limit);
            if (k > LEVELS)
                k = LEVELS;
            profit_expected.push_back((k == 0) ? '0 : sold_best[k-1]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [kmp_pkg::SOLD_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                hold_best[i] = '0;
                sold_best[i] = '0;
            end
            k_limit = 1;
            profit_expected.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (profit_expected.size() == 0)
                begin
                    $display("%0t ns: profit with nothing expected, expected none, actual %0d",
                             $time, profit);
                    fail_count++;
                end
                else
                begin
                    want = profit_expected.pop_front();
                    if (profit !== want)
                    begin
                        $display("%0t ns: profit mismatch, expected %0d, actual %0d",
                                 $time, want, profit);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_price(price, first, last);
            if (cfg_wr_en)
                k_limit = cfg_wr_data;
        end
        open_results = profit_expected.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for k_transaction_max_profit_core.
// Depends on kmp_pkg, the core, and kmp_profit_checker (prediction and compare).

module tb;

    localparam int LEVELS      = 64;
    localparam int PRICE_BITS  = 16;
    localparam int K_W         = kmp_pkg::CFG_W;
    localparam int ITEM_TARGET = 750;
    // keep a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [kmp_pkg::CFG_W-1:0]  cfg_wr_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [PRICE_BITS-1:0]      price;
    logic                       first;
    logic                       last;
    logic                       out_valid;
    logic                       out_stall;
    logic [kmp_pkg::SOLD_W-1:0] profit;

    int fail_count;
    int open_results;
    int sent;
    int cycles;
    bit no_idle;   // set per phase: both sides run without gaps

    k_transaction_max_profit_core #(
        .MAX_LEVELS (LEVELS),
        .PRICE_BITS (PRICE_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .price       (price),
        .first       (first),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .profit      (profit)
    );

    kmp_profit_checker #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .price        (price),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .profit       (profit),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t ns: timeout after %0d cycles", $time, cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Price shapes: 0 uniform, 1 rail extremes, 2 tiny values, 3 zigzag (one
    // profitable swing every two days, which pushes the deep levels).
    function automatic logic [PRICE_BITS-1:0] pick_price(input int mode, input int day);
        case (mode)
            1:       return $urandom_range(0, 1) ? '1 : '0;
            2:       return PRICE_BITS'($urandom_range(0, 15));
            3:       return day[0] ? ~PRICE_BITS'($urandom_range(0, 255)) :
                                     PRICE_BITS'($urandom_range(0, 255));
            default: return PRICE_BITS'($urandom());
        endcase
    endfunction

    // One price transaction: idle gap first, then hold valid until accepted.
    // Every edge of valid falls on its own falling clock edge.
    task automatic send_price(input logic [PRICE_BITS-1:0] p, input logic f, input logic l);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        price    <= p;
        first    <= f;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    // Well-formed sequence: first mark on day 0, last mark on the final day.
    // A one-day sequence carries both marks on the same transaction.
    task automatic send_sequence(input int days, input int mode);
        for (int d = 0; d < days; d++)
            send_price(pick_price(mode, d), d == 0, d == days - 1);
    endtask

    // Quiesce before a register write: all profits back, and the chain given
    // its full latency so no non-reporting price is still walking it.
    task automatic drain_chain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (open_results != 0)
            @(negedge clk);
        repeat (LEVELS + 8) @(negedge clk);
    endtask

    task automatic set_transactions(input logic [kmp_pkg::CFG_W-1:0] k);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Output side: a fresh random stall before each profit is taken,
    // drawn whether or not a profit is waiting, so stalls hit every phase.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = idle_cycles();
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        int random_start;
        int r;
        logic [kmp_pkg::CFG_W-1:0] k;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        price       = '0;
        first       = 1'b0;
        last        = 1'b0;
        no_idle     = 1'b0;
        sent        = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // No first mark since reset: the zeroed reset state is used as is (k = 1).
        send_price('1, 1'b0, 1'b1);
        send_price('0, 1'b0, 1'b0);
        send_price(16'h8000, 1'b0, 1'b1);
        // First and last on one transaction: nothing can be sold yet.
        send_price('1, 1'b1, 1'b1);
        // Rail-to-rail swings with the reset value of k.
        send_price('0, 1'b1, 1'b0);
        send_price('1, 1'b0, 1'b0);
        send_price('0, 1'b0, 1'b0);
        send_price('1, 1'b0, 1'b1);

        // Zero transactions allowed: profit must read 0 despite the swings.
        drain_chain();
        set_transactions(7'd0);
        send_price('0, 1'b1, 1'b0);
        send_price('1, 1'b0, 1'b0);
        send_price('0, 1'b0, 1'b0);
        send_price('1, 1'b0, 1'b1);

        // Largest register value; acts as the chain depth.
        drain_chain();
        set_transactions('1);
        send_price('0, 1'b1, 1'b0);
        send_price('1, 1'b0, 1'b0);
        send_price('0, 1'b0, 1'b0);
        send_price('1, 1'b0, 1'b0);
        send_price(16'h5555, 1'b0, 1'b0);
        send_price(16'hAAAA, 1'b0, 1'b1);

        // k changes in the middle of a sequence: levels above the old k must
        // have kept updating all along.
        drain_chain();
        set_transactions(7'd1);
        send_price(16'd100, 1'b1, 1'b0);
        send_price(16'd50, 1'b0, 1'b0);
        send_price(16'd200, 1'b0, 1'b0);
        send_price(16'd10, 1'b0, 1'b0);
        drain_chain();
        set_transactions(7'd2);
        send_price(16'd300, 1'b0, 1'b1);

        // --- random part ---
        // Phases of one k setting each; mostly well-formed sequences of random
        // content, a few long zigzags to reach deep levels, and some noise with
        // marks placed at random (missing first, missing last, repeated marks).
        random_start = sent;
        while (sent - random_start < ITEM_TARGET)
        begin
            drain_chain();
            case ($urandom_range(0, 7))
                0:       k = 7'd0;
                1:       k = 7'd1;
                2:       k = 7'd2;
                3:       k = K_W'(LEVELS);
                4:       k = K_W'($urandom_range(LEVELS + 1, 127));
                default: k = K_W'($urandom_range(1, LEVELS - 1));
            endcase
            set_transactions(k);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 7))
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_sequence($urandom_range(100, 140), 3);
                else if (r < 3)
                    repeat ($urandom_range(1, 12))
                        send_price(pick_price(0, 0), $urandom_range(0, 3) == 0,
                                   $urandom_range(0, 3) == 0);
                else
                    send_sequence($urandom_range(1, 12), $urandom_range(0, 3));
            end
        end

        // --- wind down ---
        @(negedge clk);
        in_valid <= 1'b0;
        while (open_results != 0)
            @(negedge clk);
        // let any stray profit surface before the verdict
        repeat (LEVELS + 16) @(posedge clk);
        if (fail_count == 0 && open_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
